### sv/cwac_pkg.sv
// ---------------------------------------------------------------------------
// cwac_pkg
// Shared constants and types for the chinese wall access check block:
// table sizes, command codes, register indexes and the policy result bundle.
// ---------------------------------------------------------------------------
package cwac_pkg;

  // table sizes
  localparam int SUBJECTS = 16;
  localparam int OBJECTS  = 16;
  localparam int FIRMS    = 16;
  localparam int CLASSES  = 16;

  // field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 4;
  localparam int MAP_W    = 64;
  localparam int ROW_W    = 16;
  localparam int SUBJ_AW  = (SUBJECTS > 1) ? $clog2(SUBJECTS) : 1;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 8;
  localparam int CFG_IDX_W = 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_FIRM_MAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRM_CLASS_MAP  = 1'b1;

  // row of the history memory: read bitmap over accessed bitmap
  typedef struct packed {
    logic [ROW_W-1:0] read_firms;
    logic [ROW_W-1:0] accessed_firms;
  } row_t;

  // decision handed back from the policy unit
  typedef struct packed {
    logic grant;
    logic write_row;
    row_t row;
  } decision_t;

endpackage

### sv/chinese_wall_access_check_core.sv
// ---------------------------------------------------------------------------
// chinese_wall_access_check_core
// Brewer-Nash chinese wall access monitor with per-subject history memory.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request item: command, subject, object.
//   m_* channel returns one item per request: granted in bit 0.
//   cfg_we/cfg_index/cfg_data write the object-to-firm map (index 0) and the
//   firm-to-class map (index 1); write them only while no request is open.
// Timing:
//   an item is taken in the idle state, which also issues the read of the
//   subject's history row; in the exec state the row is checked, written
//   back and the result register loaded once the output register is free.
//   A new item is not taken until the last one leaves the exec state, set
//   by the read then write of the single history row memory.
// Stall:
//   a finished result waits in the output register; a new item is still
//   taken, but its write-back waits until the output register is free.
// Reset:
//   rst clears both maps, the control state and the per-row valid bits, so
//   every history row reads as empty; no memory sweep is needed. s_tready
//   stays low while rst is high. A clear command drops all valid bits at
//   once when it completes.
// ---------------------------------------------------------------------------
module chinese_wall_access_check_core (
  input  logic                                clk,
  input  logic                                rst,
  // request: [1:0] command, [5:2] subject, [9:6] object, rest zero
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cwac_pkg::IN_W-1:0]           s_tdata,
  // result: [0] granted, rest zero
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cwac_pkg::OUT_W-1:0]          m_tdata,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [cwac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cwac_pkg::MAP_W-1:0]          cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                          state;
  logic [cwac_pkg::MAP_W-1:0]    object_firm_map;
  logic [cwac_pkg::MAP_W-1:0]    firm_class_map;
  logic [cwac_pkg::SUBJECTS-1:0] row_valid;

  logic [cwac_pkg::CMD_W-1:0]    command_q;
  logic [cwac_pkg::SUBJ_AW-1:0]  subj_q;
  logic [cwac_pkg::ID_W-1:0]     firm_q;
  logic [cwac_pkg::ID_W-1:0]     class_q;
  logic                          req_ok_q;
  logic                          granted;

  logic [cwac_pkg::CMD_W-1:0]    in_command;
  logic [cwac_pkg::ID_W-1:0]     in_subject;
  logic [cwac_pkg::ID_W-1:0]     in_object;
  logic [cwac_pkg::ID_W-1:0]     in_firm;
  logic [cwac_pkg::ID_W-1:0]     in_class;
  logic                          in_req_ok;
  logic                          accept;
  logic                          exec_done;
  logic [$bits(cwac_pkg::row_t)-1:0] ram_rdata;
  cwac_pkg::row_t                row;
  cwac_pkg::decision_t           decision;

  // request fields
  assign in_command = s_tdata[1:0];
  assign in_subject = s_tdata[5:2];
  assign in_object  = s_tdata[9:6];

  // firm and class lookup from the maps
  assign in_firm  = object_firm_map[in_object*cwac_pkg::ID_W +: cwac_pkg::ID_W];
  assign in_class = firm_class_map[in_firm*cwac_pkg::ID_W +: cwac_pkg::ID_W];
  assign in_req_ok = ((in_command == cwac_pkg::CMD_READ) ||
                      (in_command == cwac_pkg::CMD_WRITE)) &&
                     (32'(in_subject) < cwac_pkg::SUBJECTS) &&
                     (32'(in_object)  < cwac_pkg::OBJECTS) &&
                     (32'(in_firm)    < cwac_pkg::FIRMS) &&
                     (32'(in_class)   < cwac_pkg::CLASSES);

  // handshake
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign exec_done = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign m_tdata   = {{(cwac_pkg::OUT_W-1){1'b0}}, granted};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_firm_map <= '0;
      firm_class_map  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cwac_pkg::REG_OBJECT_FIRM_MAP: object_firm_map <= cfg_data;
        cwac_pkg::REG_FIRM_CLASS_MAP:  firm_class_map  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      command_q <= in_command;
      subj_q    <= cwac_pkg::SUBJ_AW'(in_subject);
      firm_q    <= in_firm;
      class_q   <= in_class;
      req_ok_q  <= in_req_ok;
    end
  end

  // history row memory
  cwac_ram #(
    .WIDTH ($bits(cwac_pkg::row_t)),
    .DEPTH (cwac_pkg::SUBJECTS)
  ) u_rows (
    .clk   (clk),
    .we    (exec_done && decision.write_row),
    .waddr (subj_q),
    .wdata (decision.row),
    .re    (accept),
    .raddr (cwac_pkg::SUBJ_AW'(in_subject)),
    .rdata (ram_rdata)
  );

  // rows never written since reset or clear read as empty
  assign row = (req_ok_q && row_valid[subj_q]) ? cwac_pkg::row_t'(ram_rdata) : '0;

  cwac_policy u_policy (
    .command        (command_q),
    .req_ok         (req_ok_q),
    .firm           (firm_q),
    .firm_class     (class_q),
    .firm_class_map (firm_class_map),
    .row            (row),
    .decision       (decision)
  );

  // sequencer and row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_done) begin
            state <= ST_IDLE;
            if (command_q == cwac_pkg::CMD_CLEAR) begin
              row_valid <= '0;
            end else if (decision.write_row) begin
              row_valid[subj_q] <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      granted <= decision.grant;
    end
  end

endmodule

### sv/cwac_ram.sv
// ---------------------------------------------------------------------------
// cwac_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module cwac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/cwac_policy.sv
// ---------------------------------------------------------------------------
// cwac_policy
// Chinese wall decision: builds the conflict class member set, checks the
// subject's history row and produces the grant and the updated row.
// ---------------------------------------------------------------------------
module cwac_policy (
  input  logic [cwac_pkg::CMD_W-1:0] command,
  input  logic                       req_ok,
  input  logic [cwac_pkg::ID_W-1:0]  firm,
  input  logic [cwac_pkg::ID_W-1:0]  firm_class,
  input  logic [cwac_pkg::MAP_W-1:0] firm_class_map,
  input  cwac_pkg::row_t             row,
  output cwac_pkg::decision_t        decision
);

  logic [cwac_pkg::ROW_W-1:0] members;
  logic [cwac_pkg::ROW_W-1:0] fbit;
  logic                       read_ok;
  logic                       write_ok;
  logic                       is_read;
  logic                       is_write;
  logic                       grant;

  // firms of the same conflict class, only those below the firm count
  always_comb begin
    for (int f = 0; f < cwac_pkg::ROW_W; f++) begin
      members[f] = (f < cwac_pkg::FIRMS) &&
                   (firm_class_map[f*cwac_pkg::ID_W +: cwac_pkg::ID_W] == firm_class);
    end
  end

  assign fbit = cwac_pkg::ROW_W'(1) << firm;

  // wall checks
  assign read_ok  = ((row.accessed_firms & members) == '0) ||
                    ((row.accessed_firms & fbit) != '0);
  assign write_ok = ((row.read_firms & members & ~fbit) == '0);

  assign is_read  = (command == cwac_pkg::CMD_READ);
  assign is_write = (command == cwac_pkg::CMD_WRITE);
  assign grant    = req_ok && read_ok && (is_read || (is_write && write_ok));

  // updated history row
  always_comb begin
    decision.grant               = grant;
    decision.write_row           = grant;
    decision.row.accessed_firms  = row.accessed_firms | fbit;
    decision.row.read_firms      = is_read ? (row.read_firms | fbit) : row.read_firms;
  end

endmodule

### sv/cwac_checker.sv
// ---------------------------------------------------------------------------
// cwac_checker
// Port-level checks for the chinese wall access check block, bound to the
// top level.
// ---------------------------------------------------------------------------
module cwac_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [cwac_pkg::IN_W-1:0]      s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cwac_pkg::OUT_W-1:0]     m_tdata
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // block is busy right after taking an item
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // a new result always follows an accepted item, and clear or unused
  // commands are never granted
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) &&
      (m_tdata[0] == 1'b0 ||
       $past(s_tdata[1:0], 2) == cwac_pkg::CMD_READ ||
       $past(s_tdata[1:0], 2) == cwac_pkg::CMD_WRITE))
    else $error("unexpected result timing or grant");

endmodule

bind chinese_wall_access_check_core cwac_checker u_cwac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
